### design/qrs_pkg.sv
// Shared widths, case codes and stage context for the quadratic root solver.
// No dependencies; every design file imports this package.
`timescale 1ns / 1ps

package qrs_pkg;

  localparam int CW   = 16;
  localparam int OW   = 32;
  localparam int OFB  = 16;
  localparam int PW   = 2 * CW;
  localparam int DW   = 2 * CW + 3;
  localparam int DMW  = 2 * CW + 2;
  localparam int RW   = DMW / 2;
  localparam int SRW  = RW + 2;
  localparam int NW   = RW + 2;
  localparam int DENW = CW + 2;
  localparam int QW   = NW - 1 + OFB;
  localparam int DRW  = DENW;
  localparam int DIV_LAT = QW + 2;

  typedef enum logic [1:0] {
    CASE_TWO_REAL = 2'd0,
    CASE_REPEATED = 2'd1,
    CASE_COMPLEX  = 2'd2,
    CASE_A_ZERO   = 2'd3
  } root_case_t;

  typedef struct packed {
    logic signed [CW-1:0] a;
    logic signed [CW-1:0] b;
    logic                 dneg;
    logic                 dzero;
  } sq_ctx_t;

endpackage

### design/qrs_div.sv
// Pipelined signed divider: (num * 2^16) / den, truncated toward zero and clamped to Q16.16.
// One quotient bit per stage. Depends on qrs_pkg.
`timescale 1ns / 1ps

module qrs_div import qrs_pkg::*; (
  input  logic                   clk,
  input  logic                   en,
  input  logic signed [NW-1:0]   num,
  input  logic signed [DENW-1:0] den,
  output logic signed [OW-1:0]   quo,
  output logic                   sat
);

  localparam logic [QW-1:0] QMAX_POS = QW'((64'd1 << (OW - 1)) - 64'd1);
  localparam logic [QW-1:0] QMAX_NEG = QW'(64'd1 << (OW - 1));

  logic [QW-1:0]     qd_q [0:QW];
  logic [DRW-1:0]    rm_q [0:QW];
  logic [DENW-2:0]   dm_q [0:QW];
  logic              ng_q [0:QW];

  logic [NW-1:0]     nabs;
  logic [DENW-1:0]   dabs;

  assign nabs = num[NW-1] ? NW'(-num) : NW'(num);
  assign dabs = den[DENW-1] ? DENW'(-den) : DENW'(den);

  always_ff @(posedge clk) begin
    if (en) begin
      qd_q[0] <= {nabs[NW-2:0], {OFB{1'b0}}};
      rm_q[0] <= '0;
      dm_q[0] <= dabs[DENW-2:0];
      ng_q[0] <= num[NW-1] ^ den[DENW-1];
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [DRW:0] r2;
    logic         take;
    assign r2   = {rm_q[k], qd_q[k][QW-1]};
    assign take = r2 >= (DRW + 1)'(dm_q[k]);
    always_ff @(posedge clk) begin
      if (en) begin
        rm_q[k+1] <= take ? DRW'(r2 - (DRW + 1)'(dm_q[k])) : DRW'(r2);
        qd_q[k+1] <= {qd_q[k][QW-2:0], take};
        dm_q[k+1] <= dm_q[k];
        ng_q[k+1] <= ng_q[k];
      end
    end
  end

  logic [QW-1:0] qm;
  logic [QW-1:0] qneg;
  assign qm   = qd_q[QW];
  assign qneg = QW'(-qm);

  always_ff @(posedge clk) begin
    if (en) begin
      if (ng_q[QW]) begin
        sat <= qm > QMAX_NEG;
        quo <= (qm > QMAX_NEG) ? $signed(OW'(QMAX_NEG)) : $signed(qneg[OW-1:0]);
      end else begin
        sat <= qm > QMAX_POS;
        quo <= (qm > QMAX_POS) ? $signed(OW'(QMAX_POS)) : $signed(qm[OW-1:0]);
      end
    end
  end

endmodule

### design/quadratic_root_solver_core.sv
// Quadratic root solver top level: discriminant, pipelined square root, two dividers.
// Depends on qrs_pkg and qrs_div.
`timescale 1ns / 1ps
//
//  Channel  Handshake             Payload
//  in       in_valid / in_ready   in_coef_a, in_coef_b, in_coef_c (signed Q8.8)
//  out      out_valid / out_ready out_root_case, out_first_value, out_second_value,
//                                 out_saturated
//
// One coefficient beat is taken every cycle while in_ready is high. The depth
// of the pipeline is set by the square root (one root bit per stage) and the
// dividers (one quotient bit per stage). The whole pipeline holds while a
// result waits at the output and out_ready is low, so nothing is lost or
// repeated. Reset clears the valid bits only.

module quadratic_root_solver_core import qrs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [CW-1:0] in_coef_a,
  input  logic signed [CW-1:0] in_coef_b,
  input  logic signed [CW-1:0] in_coef_c,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_root_case,
  output logic signed [OW-1:0] out_first_value,
  output logic signed [OW-1:0] out_second_value,
  output logic                 out_saturated
);

  logic adv;
  logic out_valid_r;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  logic                 v0_r, v1_r, v2_r;
  logic signed [CW-1:0] a0_r, b0_r, c0_r, a1_r, b1_r, a2_r, b2_r;
  logic signed [PW-1:0] bb_r, ac_r;
  logic signed [DW-1:0] d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_valid;
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a0_r <= in_coef_a;
      b0_r <= in_coef_b;
      c0_r <= in_coef_c;
      bb_r <= b0_r * b0_r;
      ac_r <= a0_r * c0_r;
      a1_r <= a0_r;
      b1_r <= b0_r;
      d_r  <= DW'(bb_r) - (DW'(ac_r) <<< 2);
      a2_r <= a1_r;
      b2_r <= b1_r;
    end
  end

  logic            sv_q   [0:RW];
  logic [DMW-1:0]  rad_q  [0:RW];
  logic [SRW-1:0]  rem_q  [0:RW];
  logic [RW-1:0]   root_q [0:RW];
  sq_ctx_t         ctx_q  [0:RW];

  logic [DW-1:0] dabs;
  assign dabs = d_r[DW-1] ? DW'(-d_r) : DW'(d_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_q[0] <= 1'b0;
    end else if (adv) begin
      sv_q[0] <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rad_q[0]       <= dabs[DMW-1:0];
      rem_q[0]       <= '0;
      root_q[0]      <= '0;
      ctx_q[0].a     <= a2_r;
      ctx_q[0].b     <= b2_r;
      ctx_q[0].dneg  <= d_r[DW-1];
      ctx_q[0].dzero <= d_r == '0;
    end
  end

  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    logic [SRW+1:0] rem_n;
    logic [SRW+1:0] trial;
    logic           take;
    assign rem_n = {rem_q[k], rad_q[k][DMW-1 -: 2]};
    assign trial = (SRW + 2)'({root_q[k], 2'b01});
    assign take  = rem_n >= trial;
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sv_q[k+1] <= 1'b0;
      end else if (adv) begin
        sv_q[k+1] <= sv_q[k];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        rem_q[k+1]  <= take ? SRW'(rem_n - trial) : SRW'(rem_n);
        root_q[k+1] <= {root_q[k][RW-2:0], take};
        rad_q[k+1]  <= {rad_q[k][DMW-3:0], 2'b00};
        ctx_q[k+1]  <= ctx_q[k];
      end
    end
  end

  sq_ctx_t                cx;
  logic signed [NW-1:0]   nb, sx;
  logic signed [DENW-1:0] den, aden;
  root_case_t             case_nxt;
  logic signed [NW-1:0]   num1_nxt, num2_nxt;
  logic signed [DENW-1:0] den2_nxt;

  assign cx   = ctx_q[RW];
  assign nb   = -NW'(cx.b);
  assign sx   = $signed({2'b00, root_q[RW]});
  assign den  = DENW'(cx.a) <<< 1;
  assign aden = den[DENW-1] ? -den : den;

  always_comb begin
    if (cx.a == '0) begin
      case_nxt = CASE_A_ZERO;
    end else if (cx.dneg) begin
      case_nxt = CASE_COMPLEX;
    end else if (cx.dzero) begin
      case_nxt = CASE_REPEATED;
    end else begin
      case_nxt = CASE_TWO_REAL;
    end
    case (case_nxt)
      CASE_COMPLEX: begin
        num1_nxt = nb;
        num2_nxt = sx;
        den2_nxt = aden;
      end
      CASE_REPEATED: begin
        num1_nxt = nb;
        num2_nxt = nb;
        den2_nxt = den;
      end
      default: begin
        num1_nxt = nb + sx;
        num2_nxt = nb - sx;
        den2_nxt = den;
      end
    endcase
  end

  logic signed [NW-1:0]   num1_r, num2_r;
  logic signed [DENW-1:0] den1_r, den2_r;
  logic                   vl_q [0:DIV_LAT];
  root_case_t             cs_q [0:DIV_LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= DIV_LAT; i++) begin
        vl_q[i] <= 1'b0;
      end
    end else if (adv) begin
      vl_q[0] <= sv_q[RW];
      for (int i = 1; i <= DIV_LAT; i++) begin
        vl_q[i] <= vl_q[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      num1_r  <= num1_nxt;
      num2_r  <= num2_nxt;
      den1_r  <= den;
      den2_r  <= den2_nxt;
      cs_q[0] <= case_nxt;
      for (int i = 1; i <= DIV_LAT; i++) begin
        cs_q[i] <= cs_q[i-1];
      end
    end
  end

  logic signed [OW-1:0] q1, q2;
  logic                 s1, s2;

  qrs_div u_div1 (
    .clk (clk),
    .en  (adv),
    .num (num1_r),
    .den (den1_r),
    .quo (q1),
    .sat (s1)
  );

  qrs_div u_div2 (
    .clk (clk),
    .en  (adv),
    .num (num2_r),
    .den (den2_r),
    .quo (q2),
    .sat (s2)
  );

  logic [1:0]           case_r;
  logic signed [OW-1:0] first_r, second_r;
  logic                 sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vl_q[DIV_LAT];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      case_r <= cs_q[DIV_LAT];
      if (cs_q[DIV_LAT] == CASE_A_ZERO) begin
        first_r  <= '0;
        second_r <= '0;
        sat_r    <= 1'b0;
      end else begin
        first_r  <= q1;
        second_r <= q2;
        sat_r    <= s1 | s2;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_root_case    = case_r;
  assign out_first_value  = first_r;
  assign out_second_value = second_r;
  assign out_saturated    = sat_r;

endmodule
